// ===== src/two_class_priority_queue_with_cancel_defines.svh =====
// Assertion helpers used by the queue datapath.
`ifndef TWO_CLASS_PRIORITY_QUEUE_WITH_CANCEL_DEFINES_SVH
`define TWO_CLASS_PRIORITY_QUEUE_WITH_CANCEL_DEFINES_SVH

// Clocked check, disabled while reset is asserted.
`define TCPQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("queue check failed");

// Same check with a caller-supplied message.
`define TCPQ_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// ===== src/tcpq_pkg.sv =====
package tcpq_pkg;

  typedef enum logic [1:0] {
    CMD_INS_REG = 2'd0,
    CMD_INS_URG = 2'd1,
    CMD_SERVE   = 2'd2,
    CMD_CANCEL  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  localparam int unsigned MaxEntriesBits = 5;
  localparam logic [MaxEntriesBits-1:0] MaxEntriesReset = 5'd10;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the command beat and its key match vector
    logic apply;    // update the queue and load the result register
  } ctrl_t;

endpackage

// ===== src/tcpq_cmd_if.sv =====
interface tcpq_cmd_if #(
  parameter int unsigned KEY_BITS = 30
);
  logic                 valid;
  logic                 ready;
  tcpq_pkg::cmd_e       command;
  logic [KEY_BITS-1:0]  entry_key;

  modport source (output valid, output command, output entry_key, input ready);
  modport sink   (input valid, input command, input entry_key, output ready);
endinterface

// ===== src/tcpq_rsp_if.sv =====
interface tcpq_rsp_if #(
  parameter int unsigned KEY_BITS   = 30,
  parameter int unsigned COUNT_BITS = 5
);
  logic                   valid;
  logic                   ready;
  tcpq_pkg::status_e      status;
  logic [KEY_BITS-1:0]    served_key;
  logic                   served_urgent;
  logic [COUNT_BITS-1:0]  entry_count;

  modport source (output valid, output status, output served_key, output served_urgent,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input served_key, input served_urgent,
                  input entry_count, output ready);
endinterface

// ===== src/tcpq_ctrl.sv =====
module tcpq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output tcpq_pkg::ctrl_t ctrl_o
);

  localparam logic StIdle  = 1'b0;
  localparam logic StApply = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign cmd_ready_o = (state_q == StIdle);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    ctrl_o         = '0;
    state_d        = state_q;
    ctrl_o.capture = cmd_valid_i && cmd_ready_o;
    unique case (state_q)
      StIdle: begin
        if (ctrl_o.capture) begin
          state_d = StApply;
        end
      end
      StApply: begin
        // hold until the result register can take the new beat
        if (out_free) begin
          ctrl_o.apply = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.apply) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/tcpq_datapath.sv =====
`include "two_class_priority_queue_with_cancel_defines.svh"

module tcpq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned KEY_BITS    = 30,
  parameter int unsigned COUNT_BITS  = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tcpq_pkg::ctrl_t                     ctrl_i,
  input  logic                                cfg_we_i,
  input  logic [tcpq_pkg::MaxEntriesBits-1:0] cfg_wdata_i,
  input  tcpq_pkg::cmd_e                      cmd_i,
  input  logic [KEY_BITS-1:0]                 key_i,
  output tcpq_pkg::status_e                   status_o,
  output logic [KEY_BITS-1:0]                 served_key_o,
  output logic                                served_urgent_o,
  output logic [COUNT_BITS-1:0]               entry_count_o
);

  localparam int unsigned CmpBits =
    (COUNT_BITS > tcpq_pkg::MaxEntriesBits) ? COUNT_BITS : tcpq_pkg::MaxEntriesBits;

  logic [KEY_BITS-1:0]                 slot_key_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]              slot_urg_q;
  logic [COUNT_BITS-1:0]               count_q, count_d;
  logic [tcpq_pkg::MaxEntriesBits-1:0] max_entries_q;
  tcpq_pkg::cmd_e                      cmd_q;
  logic [KEY_BITS-1:0]                 key_q;
  logic [QUEUE_DEPTH-1:0]              match_q;

  tcpq_pkg::status_e                   res_status_q, status_d;
  logic [KEY_BITS-1:0]                 res_key_q, rem_key;
  logic                                res_urg_q, rem_urg;

  logic [QUEUE_DEPTH-1:0] slot_valid, rem, rem_first, rem_tail, ins_tail;
  logic                   is_ins, full, hit, do_ins, do_rem;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_valid[i] = COUNT_BITS'(i) < count_q;
    end
  end

  // Full when the count reaches the limit or the physical depth.
  assign full = (CmpBits'(count_q) >= CmpBits'(max_entries_q)) ||
                (count_q == COUNT_BITS'(QUEUE_DEPTH));

  always_comb begin
    rem      = '0;
    is_ins   = 1'b0;
    status_d = tcpq_pkg::ST_OK;
    unique case (cmd_q) inside
      tcpq_pkg::CMD_INS_REG, tcpq_pkg::CMD_INS_URG: is_ins = 1'b1;
      tcpq_pkg::CMD_SERVE:  rem[0] = slot_valid[0];
      tcpq_pkg::CMD_CANCEL: rem = match_q;
      default: rem = '0;
    endcase
    hit = |rem;
    case (cmd_q)
      tcpq_pkg::CMD_SERVE:  status_d = hit ? tcpq_pkg::ST_OK : tcpq_pkg::ST_EMPTY;
      tcpq_pkg::CMD_CANCEL: status_d = hit ? tcpq_pkg::ST_OK : tcpq_pkg::ST_NOT_FOUND;
      default:              status_d = full ? tcpq_pkg::ST_FULL : tcpq_pkg::ST_OK;
    endcase
  end

  // Lowest set bit, and every slot from it upward, of the removal vector.
  assign rem_first = rem & (~rem + QUEUE_DEPTH'(1));
  assign rem_tail  = rem | (~rem + QUEUE_DEPTH'(1));

  // Slots at or past the insert point; urgent entries form a prefix.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ins_tail[i] = !slot_valid[i] ||
                    ((cmd_q == tcpq_pkg::CMD_INS_URG) && !slot_urg_q[i]);
    end
  end

  always_comb begin
    rem_key = '0;
    rem_urg = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rem_key = rem_key | (slot_key_q[i] & {KEY_BITS{rem_first[i]}});
      rem_urg = rem_urg | (slot_urg_q[i] & rem_first[i]);
    end
  end

  assign do_ins = ctrl_i.apply && is_ins && !full;
  assign do_rem = ctrl_i.apply && hit;

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + COUNT_BITS'(1);
    end else if (do_rem) begin
      count_d = count_q - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      max_entries_q <= tcpq_pkg::MaxEntriesReset;
      res_status_q  <= tcpq_pkg::ST_OK;
      res_key_q     <= '0;
      res_urg_q     <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        max_entries_q <= cfg_wdata_i;
      end
      if (ctrl_i.apply) begin
        res_status_q <= status_d;
        res_key_q    <= rem_key;
        res_urg_q    <= rem_urg;
      end
    end
  end

  // Command beat and per-slot key compare, taken together on capture.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_i;
      key_q <= key_i;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        match_q[i] <= slot_valid[i] && (slot_key_q[i] == key_i);
      end
    end
  end

  // Shift slots: up one from the insert point, down one from the removed slot.
  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      if (ins_tail[0]) begin
        slot_key_q[0] <= key_q;
        slot_urg_q[0] <= (cmd_q == tcpq_pkg::CMD_INS_URG);
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (ins_tail[i]) begin
          if (ins_tail[i-1]) begin
            slot_key_q[i] <= slot_key_q[i-1];
            slot_urg_q[i] <= slot_urg_q[i-1];
          end else begin
            slot_key_q[i] <= key_q;
            slot_urg_q[i] <= (cmd_q == tcpq_pkg::CMD_INS_URG);
          end
        end
      end
    end else if (do_rem) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (rem_tail[i]) begin
          slot_key_q[i] <= slot_key_q[i+1];
          slot_urg_q[i] <= slot_urg_q[i+1];
        end
      end
    end
  end

  assign status_o        = res_status_q;
  assign served_key_o    = res_key_q;
  assign served_urgent_o = res_urg_q;
  assign entry_count_o   = count_q;

  `TCPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= COUNT_BITS'(QUEUE_DEPTH))
  `TCPQ_ASSERT_MSG(a_ins_grows, clk_i, rst_ni, do_ins |=> count_q == $past(count_q) + COUNT_BITS'(1), "insert did not grow count")
  `TCPQ_ASSERT_MSG(a_fail_holds, clk_i, rst_ni, (ctrl_i.apply && status_d != tcpq_pkg::ST_OK) |=> $stable(count_q), "failed command changed count")
  `TCPQ_ASSERT(a_fail_zero, clk_i, rst_ni, (res_status_q != tcpq_pkg::ST_OK) |-> (res_key_q == '0 && !res_urg_q))

endmodule

// ===== src/two_class_priority_queue_with_cancel.sv =====
// Flow: a command beat accepted in idle is captured, then applied from the apply state
// once the result register is free, and its result beat is registered onto rsp_o.
// A new command is not taken until the last one has been applied; a stalled result
// register holds the apply step and so backs up cmd_i.
// Reset: asynchronous, active low; clears the count, the result valid and sets the
// entry limit to ten. Slot contents are not cleared and need no clearing pass.
module two_class_priority_queue_with_cancel #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned KEY_BITS    = 30
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tcpq_pkg::MaxEntriesBits-1:0] cfg_wdata_i,
  tcpq_cmd_if.sink                            cmd_i,
  tcpq_rsp_if.source                          rsp_o
);

  // Count must hold the depth itself, so it is sized for QUEUE_DEPTH + 1 values.
  localparam int unsigned CountBits = $clog2(QUEUE_DEPTH + 1);

  tcpq_pkg::ctrl_t   ctrl;
  tcpq_pkg::status_e status;
  logic [KEY_BITS-1:0]  served_key;
  logic                 served_urgent;
  logic [CountBits-1:0] entry_count;

  // Sequencer: accept a beat in idle, apply it from the apply state once the result
  // register is empty or draining, then drop back to idle.
  tcpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .ctrl_o      (ctrl)
  );

  // Shift-register queue: every slot compares against the key in parallel at
  // capture; apply shifts the affected slots one place up or down.
  tcpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .COUNT_BITS  (CountBits)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd_i.command),
    .key_i           (cmd_i.entry_key),
    .status_o        (status),
    .served_key_o    (served_key),
    .served_urgent_o (served_urgent),
    .entry_count_o   (entry_count)
  );

  // The count register only moves on apply, so while a result beat waits it
  // still shows the count after that command.
  assign rsp_o.status        = status;
  assign rsp_o.served_key    = served_key;
  assign rsp_o.served_urgent = served_urgent;
  assign rsp_o.entry_count   = entry_count;

endmodule
